@@ src/mprd_pkg.sv @@
// Shared types and constants of the margin priority ring deque.
package mprd_pkg;

   // Operation codes carried in the kind field of a request.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Status codes returned with every response.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_CLAMPED = 2'd3;

   // Configuration register map (word index taken from the byte address).
   localparam int         CSR_ADDR_W       = 3;
   localparam logic [0:0] REG_FRONT_MARGIN = 1'b0;
   localparam logic [15:0] MARGIN_RESET    = 16'd10;

   // Response buffer.
   localparam int RSP_FIFO_DEPTH = 3;
   localparam int RSP_PTR_W      = 2;
   localparam int RSP_FILL_W     = 2;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] item_value;
      logic        [7:0]  remove_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] head_value;
      logic               head_valid;
      logic        [7:0]  occupancy;
      logic        [1:0]  status;
   } rsp_type;

endpackage

@@ src/margin_priority_ring_deque.sv @@
// Top level of the margin priority ring deque: ring pointers, entry memory and CSR.
//
//   channel  direction  ports        transaction
//   req      in         req_*        one insert or remove command
//   rsp      out        rsp_*        head value, head valid, occupancy, status
//   csr      in/out     csr_*        APB-style access to front_margin
//
// One command is accepted per clock cycle while req_ready is high; its response is registered
// in the first stage and then in the response buffer. The head entry is cached in a register,
// and the one memory read port fetches the new head after a removal.
// Reset is synchronous; it resets the pointers, clears the count and sets the margin to 10; the
// entry memory is not cleared and needs no clearing pass.
// A stalled response channel fills a three-entry buffer, after which req_ready drops.
module margin_priority_ring_deque #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mprd_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mprd_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mprd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
   localparam int SUM_W = ((CMP_W > IDX_W) ? CMP_W : IDX_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);

   logic [IDX_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [15:0]         margin_ff;
   logic signed [31:0]  head_value_ff, head_value_in, rd_data_ff, head_cur;
   logic                head_mem_ff, head_mem_in;
   logic                s1_valid_ff;
   logic                s1_mem_ff;
   mprd_pkg::rsp_type   s1_rsp_ff, s1_rsp_in, push_data;
   logic [1:0]          status;

   logic signed [31:0]  entry_store [QUEUE_DEPTH];
   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_addr;

   logic                accept, is_empty, is_full, goes_front, clamp, csr_write;
   logic signed [33:0]  val_ext, thresh;
   logic [CMP_W-1:0]    rc_w, cnt_w, rc_eff;
   logic [SUM_W-1:0]    head_sum;
   logic [IDX_W-1:0]    head_fwd, head_dec, tail_inc;
   logic [mprd_pkg::RSP_FILL_W-1:0] fifo_fill;

   // A slot is reserved in the response buffer for the transaction still in the first stage.
   assign req_ready = ({1'b0, fifo_fill} + {{mprd_pkg::RSP_FILL_W{1'b0}}, s1_valid_ff})
                      < (mprd_pkg::RSP_FILL_W + 1)'(mprd_pkg::RSP_FIFO_DEPTH);
   assign accept    = req_valid && req_ready;

   // After a removal the new head arrives from the memory read register.
   assign head_cur = head_mem_ff ? rd_data_ff : head_value_ff;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == FULL_CNT);

   assign val_ext    = 34'(req_payload.item_value);
   assign thresh     = 34'(head_cur) + $signed({18'b0, margin_ff});
   assign goes_front = !is_empty && (val_ext >= thresh);

   assign rc_w   = CMP_W'(req_payload.remove_count);
   assign cnt_w  = CMP_W'(count_ff);
   assign clamp  = rc_w > cnt_w;
   assign rc_eff = clamp ? cnt_w : rc_w;

   assign head_sum = SUM_W'(head_ff) + SUM_W'(rc_eff);
   assign head_fwd = (head_sum >= DEPTH_S) ? IDX_W'(head_sum - DEPTH_S) : IDX_W'(head_sum);
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      head_value_in = head_cur;
      head_mem_in   = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = tail_inc;
      rd_en         = 1'b0;
      status        = mprd_pkg::STATUS_OK;
      if (accept) begin
         if (req_payload.kind == mprd_pkg::KIND_INSERT) begin
            if (is_full) begin
               status = mprd_pkg::STATUS_FULL;
            end else if (goes_front) begin
               head_in       = head_dec;
               wr_en         = 1'b1;
               wr_addr       = head_dec;
               count_in      = count_ff + 1'b1;
               head_value_in = req_payload.item_value;
            end else begin
               tail_in  = tail_inc;
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (is_empty) begin
                  head_value_in = req_payload.item_value;
               end
            end
         end else begin
            if (is_empty) begin
               status = mprd_pkg::STATUS_EMPTY;
            end else begin
               if (clamp) begin
                  status = mprd_pkg::STATUS_CLAMPED;
               end
               head_in  = head_fwd;
               count_in = count_ff - CNT_W'(rc_eff);
               if (count_in != '0) begin
                  rd_en       = 1'b1;
                  head_mem_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      s1_rsp_in.head_value = head_value_in;
      s1_rsp_in.head_valid = (count_in != '0);
      s1_rsp_in.occupancy  = 8'(count_in);
      s1_rsp_in.status     = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= LAST_IDX;
         count_ff    <= '0;
         head_mem_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         margin_ff   <= mprd_pkg::MARGIN_RESET;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         head_mem_ff <= head_mem_in;
         s1_valid_ff <= accept;
         if (csr_write) begin
            margin_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      head_value_ff <= head_value_in;
      s1_rsp_ff     <= s1_rsp_in;
      s1_mem_ff     <= head_mem_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store[wr_addr] <= req_payload.item_value;
      end
      if (rd_en) begin
         rd_data_ff <= entry_store[head_fwd];
      end
   end

   // The memory read lands in the same cycle as the first stage, so it is merged here.
   always_comb begin
      push_data = s1_rsp_ff;
      if (!s1_rsp_ff.head_valid) begin
         push_data.head_value = '0;
      end else if (s1_mem_ff) begin
         push_data.head_value = rd_data_ff;
      end
   end

   mprd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_data  (push_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_payload),
      .fill       (fifo_fill)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[mprd_pkg::CSR_ADDR_W-1:2] == mprd_pkg::REG_FRONT_MARGIN);
   assign csr_prdata = (csr_paddr[mprd_pkg::CSR_ADDR_W-1:2] == mprd_pkg::REG_FRONT_MARGIN)
                       ? {16'b0, margin_ff} : 32'b0;

endmodule

@@ src/mprd_rsp_fifo.sv @@
// Three-entry response buffer that decouples the queue datapath from the response channel.
module mprd_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push_valid,
   input  mprd_pkg::rsp_type                   push_data,
   output logic                                pop_valid,
   input  logic                                pop_ready,
   output mprd_pkg::rsp_type                   pop_data,
   output logic [mprd_pkg::RSP_FILL_W-1:0]     fill
);

   localparam logic [mprd_pkg::RSP_PTR_W-1:0] LAST_PTR =
      mprd_pkg::RSP_PTR_W'(mprd_pkg::RSP_FIFO_DEPTH - 1);

   mprd_pkg::rsp_type                   entries_ff [mprd_pkg::RSP_FIFO_DEPTH];
   logic [mprd_pkg::RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mprd_pkg::RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mprd_pkg::RSP_FILL_W-1:0]     fill_ff, fill_in;
   logic                                pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign fill      = fill_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push_valid) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/mprd_checker.sv @@
// Port-level assertions for the margin priority ring deque and their bind statement.
module mprd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mprd_pkg::rsp_type rsp_payload
);

   // An empty queue always reports a zero head and zero occupancy.
   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.head_valid |->
         rsp_payload.head_value == '0 && rsp_payload.occupancy == '0)
      else $error("empty response carries a non-zero head or occupancy");

   // A rejected or clamped removal leaves the queue empty.
   a_remove_leaves_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == mprd_pkg::STATUS_EMPTY ||
                    rsp_payload.status == mprd_pkg::STATUS_CLAMPED) |->
         !rsp_payload.head_valid)
      else $error("removal status disagrees with head_valid");

   // A full rejection can only come from a non-empty queue.
   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == mprd_pkg::STATUS_FULL |-> rsp_payload.head_valid)
      else $error("full rejection reported on an empty queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or vanished");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid directly after reset");

endmodule

bind margin_priority_ring_deque mprd_checker u_mprd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

@@ bench/margin_priority_ring_deque_tb.sv @@
// Self-checking testbench of the margin priority ring deque: directed table, then random phases.
module margin_priority_ring_deque_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH          = 128;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 163;
   localparam int INSERT_PCT [PHASES] = '{95, 60, 15, 80, 50, 97, 30, 90, 10, 70, 55, 85};
   localparam logic [mprd_pkg::CSR_ADDR_W-1:0] MARGIN_ADDR =
      mprd_pkg::CSR_ADDR_W'(4 * mprd_pkg::REG_FRONT_MARGIN);

   typedef enum logic {ROW_ITEM, ROW_MARGIN} row_kind_type;

   typedef struct packed {
      row_kind_type       what;
      logic               kind;
      logic signed [31:0] value;
      logic        [7:0]  count;
      logic        [15:0] margin;
      logic               typed;
      logic signed [31:0] head;
      logic               valid;
      logic        [7:0]  occ;
      logic        [1:0]  status;
   } plan_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   mprd_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   mprd_pkg::rsp_type rsp_payload;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [mprd_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // Side information travelling with the payload: a hand-written expectation, if any.
   logic              drv_typed   = 1'b0;
   mprd_pkg::rsp_type drv_exp     = '0;

   // Predictor state.
   logic signed [31:0] ring_mem [QDEPTH];
   logic        [6:0]  head_ptr = '0;
   logic        [6:0]  tail_ptr = 7'(QDEPTH - 1);
   logic        [7:0]  fill     = '0;
   logic        [15:0] margin_q = mprd_pkg::MARGIN_RESET;

   mprd_pkg::rsp_type expected_views [$];
   int          mismatch_count = 0;
   logic [15:0] stall_tick = '0;

   margin_priority_ring_deque u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 50) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // Applies one command to the predicted deque and returns the view it leaves behind.
   function automatic mprd_pkg::rsp_type apply_deque_op(input mprd_pkg::req_type r);
      mprd_pkg::rsp_type v;
      logic [7:0]        drop;
      v = '0;
      v.status = mprd_pkg::STATUS_OK;
      if (r.kind == mprd_pkg::KIND_INSERT) begin
         if (fill >= QDEPTH) begin
            v.status = mprd_pkg::STATUS_FULL;
         end else if (fill != 0 && longint'($signed(r.item_value)) >=
                      longint'($signed(ring_mem[head_ptr])) + longint'(margin_q)) begin
            head_ptr = head_ptr - 7'd1;
            ring_mem[head_ptr] = r.item_value;
            fill = fill + 8'd1;
         end else begin
            tail_ptr = tail_ptr + 7'd1;
            ring_mem[tail_ptr] = r.item_value;
            fill = fill + 8'd1;
         end
      end else begin
         if (fill == 0) begin
            v.status = mprd_pkg::STATUS_EMPTY;
         end else begin
            drop = r.remove_count;
            if (drop > fill) begin
               drop = fill;
               v.status = mprd_pkg::STATUS_CLAMPED;
            end
            // A drop of the whole depth leaves the head pointer where it was.
            head_ptr = head_ptr + drop[6:0];
            fill = fill - drop;
         end
      end
      if (fill != 0) begin
         v.head_value = ring_mem[head_ptr];
         v.head_valid = 1'b1;
      end
      v.occupancy = fill;
      return v;
   endfunction

   // Builds a random command; many values sit right at the margin boundary of the current head.
   function automatic mprd_pkg::req_type random_item(input int insert_pct);
      mprd_pkg::req_type r;
      longint            target;
      r.kind = ($urandom_range(99) < insert_pct) ? mprd_pkg::KIND_INSERT : mprd_pkg::KIND_REMOVE;
      case ($urandom_range(9))
         0: r.item_value = 32'sh7FFF_FFFF;
         1: r.item_value = 32'sh8000_0000;
         2, 3, 4: begin
            if (fill != 0) begin
               target = longint'($signed(ring_mem[head_ptr])) + longint'(margin_q)
                        + longint'($urandom_range(2)) - 64'sd1;
               if (target > 64'sd2147483647) target = 64'sd2147483647;
               if (target < -64'sd2147483648) target = -64'sd2147483648;
               r.item_value = target[31:0];
            end else begin
               r.item_value = $urandom;
            end
         end
         default: r.item_value = $urandom;
      endcase
      case ($urandom_range(9))
         0: r.remove_count = 8'd0;
         1: r.remove_count = fill;
         2: r.remove_count = 8'(fill + 8'd1);
         3: r.remove_count = 8'd255;
         4: r.remove_count = 8'd128;
         5, 6: r.remove_count = 8'($urandom_range(1, 3));
         default: r.remove_count = 8'($urandom_range(255));
      endcase
      return r;
   endfunction

   task automatic send_item(input mprd_pkg::req_type r, input logic typed,
                            input mprd_pkg::rsp_type e);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      drv_typed   <= typed;
      drv_exp     <= e;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Drops valid and waits until every outstanding response has come back.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
   endtask

   // Optionally writes front_margin, then reads it back against the predicted value.
   task automatic margin_access(input logic [15:0] value, input bit do_write);
      if (do_write) begin
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= MARGIN_ADDR;
         csr_pwdata  <= 32'(value);
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         margin_q = value;
      end
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= MARGIN_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(margin_q)) begin
         report_mismatch($sformatf("front_margin read %0h, expected %0h", csr_prdata, margin_q));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Prediction on every accepted command, and comparison on every accepted response.
   always @(posedge clock) begin
      mprd_pkg::rsp_type pred;
      mprd_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pred = apply_deque_op(req_payload);
            expected_views.push_back(drv_typed ? drv_exp : pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               report_mismatch("response transaction with nothing outstanding");
            end else begin
               want = expected_views.pop_front();
               if (rsp_payload.head_value !== want.head_value)
                  report_mismatch($sformatf("head_value %0d, expected %0d",
                                            rsp_payload.head_value, want.head_value));
               if (rsp_payload.head_valid !== want.head_valid)
                  report_mismatch($sformatf("head_valid %0b, expected %0b",
                                            rsp_payload.head_valid, want.head_valid));
               if (rsp_payload.occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_payload.occupancy, want.occupancy));
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, want.status));
            end
         end
      end
   end

   // The receiver cycles through steady, random, short-stall and long-stall patterns.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      case (stall_tick[9:8])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= 1'($urandom_range(1));
         2'd2:    rsp_ready <= (stall_tick % 16'd11) < 16'd7;
         default: rsp_ready <= (stall_tick % 16'd37) < 16'd5;
      endcase
   end

   initial begin
      plan_row_type      plan [22];
      mprd_pkg::req_type r;
      mprd_pkg::rsp_type e;
      logic [15:0]       mval;
      int                burst_left;
      bit                idle_free;

      plan = '{
         '{ROW_ITEM,   mprd_pkg::KIND_REMOVE, 32'sd0,          8'd5,   16'd0,     1'b1,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_EMPTY},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sh7FFF_FFFF,  8'd0,   16'd0,     1'b1,
           32'sh7FFF_FFFF,  1'b1, 8'd1, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sh8000_0000,  8'd0,   16'd0,     1'b1,
           32'sh7FFF_FFFF,  1'b1, 8'd2, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sh7FFF_FFFF,  8'd0,   16'd0,     1'b1,
           32'sh7FFF_FFFF,  1'b1, 8'd3, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_REMOVE, 32'sd0,          8'd0,   16'd0,     1'b1,
           32'sh7FFF_FFFF,  1'b1, 8'd3, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_REMOVE, 32'sd0,          8'd128, 16'd0,     1'b1,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_CLAMPED},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sd100,        8'd0,   16'd0,     1'b1,
           32'sd100,        1'b1, 8'd1, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sd110,        8'd0,   16'd0,     1'b1,
           32'sd110,        1'b1, 8'd2, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sd119,        8'd0,   16'd0,     1'b1,
           32'sd110,        1'b1, 8'd3, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sd120,        8'd0,   16'd0,     1'b1,
           32'sd120,        1'b1, 8'd4, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_REMOVE, 32'sd0,          8'd1,   16'd0,     1'b0,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_REMOVE, -32'sd1,         8'd3,   16'd0,     1'b1,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_OK},
         '{ROW_MARGIN, mprd_pkg::KIND_INSERT, 32'sd0,          8'd0,   16'd0,     1'b0,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, -32'sd5,         8'hFF,  16'd0,     1'b1,
           -32'sd5,         1'b1, 8'd1, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, -32'sd5,         8'd0,   16'd0,     1'b1,
           -32'sd5,         1'b1, 8'd2, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, -32'sd6,         8'd0,   16'd0,     1'b0,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_OK},
         '{ROW_MARGIN, mprd_pkg::KIND_INSERT, 32'sd0,          8'd0,   16'hFFFF,  1'b0,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sd65529,      8'd0,   16'd0,     1'b1,
           -32'sd5,         1'b1, 8'd4, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sd65530,      8'd0,   16'd0,     1'b1,
           32'sd65530,      1'b1, 8'd5, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_INSERT, 32'sh8000_0000,  8'd0,   16'd0,     1'b0,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_OK},
         '{ROW_ITEM,   mprd_pkg::KIND_REMOVE, 32'sd0,          8'd255, 16'd0,     1'b1,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_CLAMPED},
         '{ROW_MARGIN, mprd_pkg::KIND_INSERT, 32'sd0,          8'd0,
           mprd_pkg::MARGIN_RESET, 1'b0,
           32'sd0,          1'b0, 8'd0, mprd_pkg::STATUS_OK}
      };
      burst_left = 0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // The margin must come out of reset at its documented value.
      margin_access(16'd0, 1'b0);

      foreach (plan[i]) begin
         if (plan[i].what == ROW_MARGIN) begin
            drain();
            margin_access(plan[i].margin, 1'b1);
         end else begin
            r = '{plan[i].kind, plan[i].value, plan[i].count};
            e = '{plan[i].head, plan[i].valid, plan[i].occ, plan[i].status};
            send_item(r, plan[i].typed, e);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph % 4)
            0:       mval = 16'd0;
            1:       mval = 16'hFFFF;
            2:       mval = mprd_pkg::MARGIN_RESET;
            default: mval = 16'($urandom_range(65535));
         endcase
         margin_access(mval, 1'b1);
         idle_free = (ph % 3 == 0);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            send_item(random_item(INSERT_PCT[ph]), 1'b0, '0);
            if (!idle_free) begin
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  idle_gap($urandom_range(1, 6));
               end else begin
                  burst_left--;
               end
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d responses outstanding", expected_views.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
src/mprd_pkg.sv
src/mprd_rsp_fifo.sv
src/margin_priority_ring_deque.sv
src/mprd_checker.sv
bench/margin_priority_ring_deque_tb.sv
